@@ rtl/core/htfa_pkg.sv @@
package htfa_pkg;

  // Width of one sensor code, of one frame byte and of a byte position; PosCheck closes a frame.
  localparam int unsigned CodeW   = 20;
  localparam int unsigned ByteW   = 8;
  localparam int unsigned PosW    = 3;

  localparam logic [PosW-1:0] PosStatus = 3'd0;
  localparam logic [PosW-1:0] PosHum1   = 3'd1;
  localparam logic [PosW-1:0] PosHum2   = 3'd2;
  localparam logic [PosW-1:0] PosMixed  = 3'd3;
  localparam logic [PosW-1:0] PosTemp1  = 3'd4;
  localparam logic [PosW-1:0] PosTemp2  = 3'd5;
  localparam logic [PosW-1:0] PosCheck  = 3'd6;

  // Scaling: humidity = (S*20000 + n*2^20)/(n*2^21), temperature = (S*40000 - n*9999*2^20)/(n*2^21).
  localparam int unsigned HumScale   = 20000;
  localparam int unsigned TempScale  = 40000;
  localparam int unsigned TempOffset = 9999;
  localparam int unsigned HalfShift  = 20;
  localparam int unsigned FracShift  = 21;

  localparam int unsigned TempW = 15;
  localparam int unsigned HumW  = 14;
  localparam int unsigned UsedW = 2;

  typedef struct packed {
    logic            cap_en;
    logic [PosW-1:0] cap_pos;
    logic            store_en;
    logic            sum_clear;
    logic            sum_en;
    logic            mul_en;
    logic            div_load;
    logic            div_en;
    logic            out_load;
  } cmd_t;

  typedef struct packed {
    logic sum_last;
    logic out_free;
  } status_t;

endpackage

@@ rtl/core/htfa_ctrl.sv @@
module htfa_ctrl #(
  parameter int unsigned DEPTH = 3
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  logic              frame_start_i,
  input  htfa_pkg::status_t status_i,
  output htfa_pkg::cmd_t    cmd_o
);

  localparam int unsigned CntW  = $clog2(DEPTH + 1);
  localparam int unsigned DivW  = CntW + 15;
  localparam int unsigned DCntW = $clog2(DivW);

  typedef enum logic [5:0] {
    ST_IDLE = 6'b000001,
    ST_SUM  = 6'b000010,
    ST_MUL  = 6'b000100,
    ST_ADD  = 6'b001000,
    ST_DIV  = 6'b010000,
    ST_DONE = 6'b100000
  } state_e;

  state_e                        state_q, state_d;
  logic [htfa_pkg::PosW-1:0]     byte_pos_q, byte_pos_d;
  logic [DCntW-1:0]              div_cnt_q, div_cnt_d;
  logic [htfa_pkg::PosW-1:0]     pos;
  logic                          accept;

  assign accept     = in_valid_i && (state_q == ST_IDLE);
  assign in_stall_o = (state_q != ST_IDLE);
  assign pos        = frame_start_i ? htfa_pkg::PosStatus : byte_pos_q;

  always_comb begin
    state_d    = state_q;
    byte_pos_d = byte_pos_q;
    div_cnt_d  = div_cnt_q;
    cmd_o      = '0;
    cmd_o.cap_pos = pos;
    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          cmd_o.cap_en = 1'b1;
          if (pos == htfa_pkg::PosCheck) begin
            byte_pos_d      = htfa_pkg::PosStatus;
            cmd_o.store_en  = 1'b1;
            cmd_o.sum_clear = 1'b1;
            state_d         = ST_SUM;
          end else begin
            byte_pos_d = pos + 3'd1;
          end
        end
      end
      ST_SUM: begin
        cmd_o.sum_en = 1'b1;
        if (status_i.sum_last) begin
          state_d = ST_MUL;
        end
      end
      ST_MUL: begin
        cmd_o.mul_en = 1'b1;
        state_d      = ST_ADD;
      end
      ST_ADD: begin
        cmd_o.div_load = 1'b1;
        div_cnt_d      = '0;
        state_d        = ST_DIV;
      end
      ST_DIV: begin
        cmd_o.div_en = 1'b1;
        div_cnt_d    = div_cnt_q + 1'b1;
        if (div_cnt_q == DCntW'(DivW - 1)) begin
          state_d = ST_DONE;
        end
      end
      ST_DONE: begin
        if (status_i.out_free) begin
          cmd_o.out_load = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      byte_pos_q <= htfa_pkg::PosStatus;
      div_cnt_q  <= '0;
    end else begin
      state_q    <= state_d;
      byte_pos_q <= byte_pos_d;
      div_cnt_q  <= div_cnt_d;
    end
  end

endmodule

@@ rtl/core/htfa_datapath.sv @@
module htfa_datapath #(
  parameter int unsigned DEPTH = 3
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  htfa_pkg::cmd_t                   cmd_i,
  output htfa_pkg::status_t                status_o,
  input  logic [htfa_pkg::ByteW-1:0]       rx_byte_i,
  output logic                             out_valid_o,
  input  logic                             out_stall_i,
  output logic signed [htfa_pkg::TempW-1:0] temperature_centi_o,
  output logic [htfa_pkg::HumW-1:0]        humidity_centi_o,
  output logic [htfa_pkg::UsedW-1:0]       samples_used_o
);

  localparam int unsigned CodeW  = htfa_pkg::CodeW;
  localparam int unsigned CntW   = $clog2(DEPTH + 1);
  localparam int unsigned IdxW   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned SumW   = CodeW + CntW;
  localparam int unsigned ProdHW = SumW + 15;
  localparam int unsigned ProdTW = SumW + 16;
  localparam int unsigned OffW   = CntW + 14;
  localparam int unsigned WideW  = SumW + 16;
  localparam int unsigned DivW   = WideW - htfa_pkg::FracShift;

  logic [2*CodeW-1:0] partial_q;
  logic [CodeW-1:0]   humid_ring_q [DEPTH];
  logic [CodeW-1:0]   temp_ring_q  [DEPTH];
  logic [IdxW-1:0]    write_slot_q;
  logic [CntW-1:0]    fill_q;
  logic [IdxW-1:0]    rd_idx_q;
  logic [SumW-1:0]    sum_h_q, sum_t_q;
  logic [ProdHW-1:0]  prod_h_q;
  logic [ProdTW-1:0]  prod_t_q;
  logic [OffW-1:0]    off_q;
  logic [DivW-1:0]    quo_h_q, quo_t_q;
  logic [CntW-1:0]    rem_h_q, rem_t_q;
  logic               neg_q;
  logic               out_valid_q;
  logic signed [htfa_pkg::TempW-1:0] temp_q;
  logic [htfa_pkg::HumW-1:0]         hum_q;
  logic [htfa_pkg::UsedW-1:0]        used_q;

  logic [WideW-1:0]   hum_wide, temp_a, temp_b, temp_mag;
  logic               temp_neg;
  logic [CntW:0]      trial_h, trial_t;
  logic               bit_h, bit_t;
  logic [htfa_pkg::TempW-1:0] temp_abs;

  assign status_o.sum_last = ((CntW'(rd_idx_q) + 1'b1) == fill_q);
  assign status_o.out_free = !out_valid_q || !out_stall_i;

  // Frame byte capture into the partial codes.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      partial_q <= '0;
    end else if (cmd_i.cap_en) begin
      case (cmd_i.cap_pos)
        htfa_pkg::PosHum1:  partial_q[39:32] <= rx_byte_i;
        htfa_pkg::PosHum2:  partial_q[31:24] <= rx_byte_i;
        htfa_pkg::PosMixed: partial_q[23:16] <= rx_byte_i;
        htfa_pkg::PosTemp1: partial_q[15:8]  <= rx_byte_i;
        htfa_pkg::PosTemp2: partial_q[7:0]   <= rx_byte_i;
        default: ;
      endcase
    end
  end

  // Ring storage; entries hold no reset value and are read only once written.
  always_ff @(posedge clk_i) begin
    if (cmd_i.store_en) begin
      humid_ring_q[write_slot_q] <= partial_q[2*CodeW-1:CodeW];
      temp_ring_q[write_slot_q]  <= partial_q[CodeW-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      write_slot_q <= '0;
      fill_q       <= '0;
    end else if (cmd_i.store_en) begin
      if (write_slot_q == IdxW'(DEPTH - 1)) begin
        write_slot_q <= '0;
      end else begin
        write_slot_q <= write_slot_q + 1'b1;
      end
      if (fill_q != CntW'(DEPTH)) begin
        fill_q <= fill_q + 1'b1;
      end
    end
  end

  // Accumulate stored frames, one slot per cycle.
  always_ff @(posedge clk_i) begin
    if (cmd_i.sum_clear) begin
      rd_idx_q <= '0;
      sum_h_q  <= '0;
      sum_t_q  <= '0;
    end else if (cmd_i.sum_en) begin
      rd_idx_q <= rd_idx_q + 1'b1;
      sum_h_q  <= sum_h_q + SumW'(humid_ring_q[rd_idx_q]);
      sum_t_q  <= sum_t_q + SumW'(temp_ring_q[rd_idx_q]);
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.mul_en) begin
      prod_h_q <= ProdHW'(sum_h_q) * ProdHW'(htfa_pkg::HumScale);
      prod_t_q <= ProdTW'(sum_t_q) * ProdTW'(htfa_pkg::TempScale);
      off_q    <= OffW'(fill_q) * OffW'(htfa_pkg::TempOffset);
    end
  end

  // Rounding offset for humidity; signed temperature split into sign and magnitude.
  always_comb begin
    hum_wide = WideW'(prod_h_q) + (WideW'(fill_q) << htfa_pkg::HalfShift);
    temp_a   = WideW'(prod_t_q);
    temp_b   = WideW'(off_q) << htfa_pkg::HalfShift;
    temp_neg = temp_a < temp_b;
    temp_mag = temp_neg ? (temp_b - temp_a) : (temp_a - temp_b);
  end

  // Two restoring divider lanes by the frame count, one quotient bit per cycle.
  always_comb begin
    trial_h = {rem_h_q, quo_h_q[DivW-1]};
    trial_t = {rem_t_q, quo_t_q[DivW-1]};
    bit_h   = trial_h >= {1'b0, fill_q};
    bit_t   = trial_t >= {1'b0, fill_q};
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.div_load) begin
      quo_h_q <= hum_wide[WideW-1:htfa_pkg::FracShift];
      quo_t_q <= temp_mag[WideW-1:htfa_pkg::FracShift];
      rem_h_q <= '0;
      rem_t_q <= '0;
      neg_q   <= temp_neg;
    end else if (cmd_i.div_en) begin
      quo_h_q <= {quo_h_q[DivW-2:0], bit_h};
      quo_t_q <= {quo_t_q[DivW-2:0], bit_t};
      rem_h_q <= bit_h ? CntW'(trial_h - {1'b0, fill_q}) : trial_h[CntW-1:0];
      rem_t_q <= bit_t ? CntW'(trial_t - {1'b0, fill_q}) : trial_t[CntW-1:0];
    end
  end

  assign temp_abs = htfa_pkg::TempW'(quo_t_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.out_load) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      temp_q <= neg_q ? -temp_abs : temp_abs;
      hum_q  <= htfa_pkg::HumW'(quo_h_q);
      used_q <= htfa_pkg::UsedW'(fill_q);
    end
  end

  assign out_valid_o         = out_valid_q;
  assign temperature_centi_o = temp_q;
  assign humidity_centi_o    = hum_q;
  assign samples_used_o      = used_q;

endmodule

@@ rtl/core/humidity_temp_frame_averager.sv @@
// Frame averager for a humidity and temperature sensor.
// The input channel (in_valid_i / in_stall_o) takes one frame byte per item,
// status byte first and check byte last; frame_start_i marks byte 0.
// Bytes 0 to 5 are taken without a stall and give no result.
// The check byte stores both codes in rings of the last DEPTH frames and
// starts the arithmetic: the ring sum over the stored frames (1 to DEPTH),
// then a multiply step, an offset add that loads the divider, a restoring
// divide by the frame count with one quotient bit per cycle, and the load
// of the output register.
// The input stalls while this runs, and longer while a finished result
// waits for the output register to be free.
// The output channel (out_valid_o / out_stall_i) carries one item from an
// output register; byte items keep flowing while it waits to be taken, and
// a finished result waits for it only if the previous one is still stalled.
// Reset clears the byte position, the partial codes, the ring slot and the
// frame count; the ring contents are read only after they have been written.
module humidity_temp_frame_averager #(
  parameter int unsigned DEPTH = 3
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  logic [htfa_pkg::ByteW-1:0]        rx_byte_i,
  input  logic                              frame_start_i,
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output logic signed [htfa_pkg::TempW-1:0] temperature_centi_o,
  output logic [htfa_pkg::HumW-1:0]         humidity_centi_o,
  output logic [htfa_pkg::UsedW-1:0]        samples_used_o
);

  htfa_pkg::cmd_t    cmd;
  htfa_pkg::status_t status;

  htfa_ctrl #(
    .DEPTH (DEPTH)
  ) u_ctrl (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .frame_start_i (frame_start_i),
    .status_i      (status),
    .cmd_o         (cmd)
  );

  htfa_datapath #(
    .DEPTH (DEPTH)
  ) u_datapath (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .cmd_i               (cmd),
    .status_o            (status),
    .rx_byte_i           (rx_byte_i),
    .out_valid_o         (out_valid_o),
    .out_stall_i         (out_stall_i),
    .temperature_centi_o (temperature_centi_o),
    .humidity_centi_o    (humidity_centi_o),
    .samples_used_o      (samples_used_o)
  );

endmodule

@@ verif/tb_humidity_temp_frame_averager.sv @@
module tb_humidity_temp_frame_averager;

  localparam int unsigned RingDepth     = 3;
  localparam int unsigned PhaseBytes    = 400;
  localparam int unsigned WatchdogLimit = 2000;
  localparam int unsigned DrainCycles   = 60;

  typedef struct packed {
    logic signed [htfa_pkg::TempW-1:0] temp;
    logic [htfa_pkg::HumW-1:0]         hum;
    logic [htfa_pkg::UsedW-1:0]        used;
  } average_t;

  // Tracks the frame decoder and the averaging rings, and holds the
  // averages that the check bytes seen so far must still produce, oldest first.
  class avg_frame_tracker;
    int unsigned                ring_depth;
    logic [htfa_pkg::PosW-1:0]  byte_pos;
    logic [htfa_pkg::CodeW-1:0] hum_code;
    logic [htfa_pkg::CodeW-1:0] temp_code;
    logic [htfa_pkg::CodeW-1:0] hum_ring [16];
    logic [htfa_pkg::CodeW-1:0] temp_ring [16];
    int unsigned                write_slot;
    int unsigned                fill_count;
    average_t                   averages_q[$];
    int unsigned                mismatches;

    function new(int unsigned depth);
      ring_depth = depth;
      byte_pos   = htfa_pkg::PosStatus;
      hum_code   = '0;
      temp_code  = '0;
      write_slot = 0;
      fill_count = 0;
      mismatches = 0;
    endfunction

    function void note_byte(logic [htfa_pkg::ByteW-1:0] b, logic start);
      longint unsigned hum_sum;
      longint unsigned temp_sum;
      longint unsigned frames;
      longint unsigned hum_val;
      longint signed   temp_num;
      longint signed   temp_den;
      longint signed   temp_val;
      int unsigned     i;
      average_t        avg;

      if (start) byte_pos = htfa_pkg::PosStatus;
      case (byte_pos)
        htfa_pkg::PosHum1: hum_code[19:12] = b;
        htfa_pkg::PosHum2: hum_code[11:4] = b;
        htfa_pkg::PosMixed: begin
          hum_code[3:0]    = b[7:4];
          temp_code[19:16] = b[3:0];
        end
        htfa_pkg::PosTemp1: temp_code[15:8] = b;
        htfa_pkg::PosTemp2: temp_code[7:0] = b;
        default: ;
      endcase
      if (byte_pos != htfa_pkg::PosCheck) begin
        byte_pos = byte_pos + 1'b1;
        return;
      end

      byte_pos = htfa_pkg::PosStatus;
      if (write_slot >= ring_depth) write_slot = 0;
      hum_ring[write_slot]  = hum_code;
      temp_ring[write_slot] = temp_code;
      write_slot = (write_slot + 1 >= ring_depth) ? 0 : write_slot + 1;
      if (fill_count < ring_depth) fill_count++;

      hum_sum  = 0;
      temp_sum = 0;
      for (i = 0; i < fill_count; i++) begin
        hum_sum  += hum_ring[i];
        temp_sum += temp_ring[i];
      end
      frames = fill_count;

      // Rounding to nearest is folded into the humidity numerator; the temperature
      // division truncates toward zero, which signed division does here.
      hum_val  = (hum_sum * htfa_pkg::HumScale + (frames << htfa_pkg::HalfShift)) /
                 (frames << htfa_pkg::FracShift);
      temp_num = longint'(temp_sum * htfa_pkg::TempScale) -
                 longint'((frames * htfa_pkg::TempOffset) << htfa_pkg::HalfShift);
      temp_den = longint'(frames << htfa_pkg::FracShift);
      temp_val = temp_num / temp_den;

      avg.temp = temp_val[htfa_pkg::TempW-1:0];
      avg.hum  = hum_val[htfa_pkg::HumW-1:0];
      avg.used = fill_count[htfa_pkg::UsedW-1:0];
      averages_q.push_back(avg);
    endfunction

    function void check_average(logic signed [htfa_pkg::TempW-1:0] t,
                                logic [htfa_pkg::HumW-1:0] h,
                                logic [htfa_pkg::UsedW-1:0] u);
      average_t avg;
      if (averages_q.size() == 0) begin
        $error("unexpected item: temperature_centi %0d humidity_centi %0d samples_used %0d",
               t, h, u);
        mismatches++;
        return;
      end
      avg = averages_q.pop_front();
      if (t !== avg.temp) begin
        $error("temperature_centi: expected %0d, actual %0d", avg.temp, t);
        mismatches++;
      end
      if (h !== avg.hum) begin
        $error("humidity_centi: expected %0d, actual %0d", avg.hum, h);
        mismatches++;
      end
      if (u !== avg.used) begin
        $error("samples_used: expected %0d, actual %0d", avg.used, u);
        mismatches++;
      end
    endfunction
  endclass

  logic                              clk_i         = 1'b0;
  logic                              rst_ni        = 1'b0;
  logic                              in_valid_i    = 1'b0;
  logic                              in_stall_o;
  logic [htfa_pkg::ByteW-1:0]        rx_byte_i     = '0;
  logic                              frame_start_i = 1'b0;
  logic                              out_valid_o;
  logic                              out_stall_i   = 1'b0;
  logic signed [htfa_pkg::TempW-1:0] temperature_centi_o;
  logic [htfa_pkg::HumW-1:0]         humidity_centi_o;
  logic [htfa_pkg::UsedW-1:0]        samples_used_o;

  avg_frame_tracker tracker;
  int unsigned      src_idle_pct   = 9;
  int unsigned      sink_stall_pct = 84;
  int unsigned      bytes_sent     = 0;
  int unsigned      quiet_cycles   = 0;

  humidity_temp_frame_averager #(
    .DEPTH(RingDepth)
  ) dut (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .in_valid_i         (in_valid_i),
    .in_stall_o         (in_stall_o),
    .rx_byte_i          (rx_byte_i),
    .frame_start_i      (frame_start_i),
    .out_valid_o        (out_valid_o),
    .out_stall_i        (out_stall_i),
    .temperature_centi_o(temperature_centi_o),
    .humidity_centi_o   (humidity_centi_o),
    .samples_used_o     (samples_used_o)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    out_stall_i <= ($urandom_range(99) < sink_stall_pct);
  end

  // Handshakes are judged at the falling edge, where everything driven at
  // the last rising edge has settled and holds until the next one.
  always @(negedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      tracker.check_average(temperature_centi_o, humidity_centi_o, samples_used_o);
    end
  end

  always @(negedge clk_i) begin
    if (!rst_ni || (in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= WatchdogLimit) begin
        $display("Mismatches found");
        $finish;
      end
    end
  end

  task automatic send_byte(input logic [htfa_pkg::ByteW-1:0] b, input logic start);
    while ($urandom_range(99) < src_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i    <= 1'b1;
    rx_byte_i     <= b;
    frame_start_i <= start;
    @(negedge clk_i);
    while (in_stall_o) @(negedge clk_i);
    tracker.note_byte(b, start);
    bytes_sent++;
    @(posedge clk_i);
  endtask

  task automatic send_frame(input logic [htfa_pkg::CodeW-1:0] hum,
                            input logic [htfa_pkg::CodeW-1:0] temp,
                            input logic start);
    send_byte(htfa_pkg::ByteW'($urandom), start);
    send_byte(hum[19:12], 1'b0);
    send_byte(hum[11:4], 1'b0);
    send_byte({hum[3:0], temp[19:16]}, 1'b0);
    send_byte(temp[15:8], 1'b0);
    send_byte(temp[7:0], 1'b0);
    send_byte(htfa_pkg::ByteW'($urandom), 1'b0);
  endtask

  function automatic logic [htfa_pkg::CodeW-1:0] rand_code();
    case ($urandom_range(7))
      0: return '0;
      1: return '1;
      default: return htfa_pkg::CodeW'($urandom);
    endcase
  endfunction

  // Mostly whole frames with random codes; the rest are cut-off frames and
  // loose bytes with a random frame start flag.
  task automatic run_random(input int unsigned target);
    int unsigned stop_at;
    int unsigned kind;
    int unsigned len;
    int unsigned k;
    stop_at = bytes_sent + target;
    while (bytes_sent < stop_at) begin
      kind = $urandom_range(99);
      if (kind < 80) begin
        send_frame(rand_code(), rand_code(), $urandom_range(3) != 0);
      end else if (kind < 90) begin
        len = $urandom_range(6, 1);
        send_byte(htfa_pkg::ByteW'($urandom), 1'b1);
        for (k = 1; k < len; k++) send_byte(htfa_pkg::ByteW'($urandom), 1'b0);
      end else begin
        len = $urandom_range(10, 1);
        for (k = 0; k < len; k++) begin
          send_byte(htfa_pkg::ByteW'($urandom), $urandom_range(3) == 0);
        end
      end
    end
  endtask

  task automatic wait_for_results();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (tracker.averages_q.size() != 0);
  endtask

  initial begin
    tracker = new(RingDepth);
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // All-zero codes, then all-ones codes without a frame start flag, then
    // a frame cut short by a new frame start, and a whole frame after it.
    send_frame('0, '0, 1'b1);
    send_frame('1, '1, 1'b0);
    send_byte(8'hFF, 1'b1);
    send_byte(8'hA5, 1'b0);
    send_byte(8'h5A, 1'b0);
    send_frame(20'h80000, 20'h66666, 1'b1);

    run_random(PhaseBytes);
    wait_for_results();
    src_idle_pct   = 84;
    sink_stall_pct = 9;
    run_random(PhaseBytes);
    wait_for_results();
    src_idle_pct   = 0;
    sink_stall_pct = 0;
    run_random(PhaseBytes);
    wait_for_results();
    repeat (DrainCycles) @(posedge clk_i);

    if (tracker.mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
rtl/core/htfa_pkg.sv
rtl/core/htfa_ctrl.sv
rtl/core/htfa_datapath.sv
rtl/core/humidity_temp_frame_averager.sv
verif/tb_humidity_temp_frame_averager.sv
